// ===== rtl/core/knn_pkg.sv =====
`default_nettype none

package knn_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_K_DEF      = 32;
    localparam int NUM_LABELS     = 16;
    localparam int VALUE_BITS     = 24;

    localparam int DIST_BITS      = VALUE_BITS + 1;
    localparam int LABEL_BITS     = 5;
    localparam int LABEL_OUT_BITS = $clog2(NUM_LABELS);
    localparam int INDEX_BITS     = 6;
    localparam int TSIZE_BITS     = 7;
    localparam int KCFG_BITS      = 6;
    localparam int KCFG_RESET     = 3;

    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam logic REG_TABLE_SIZE     = 1'b0;
    localparam logic REG_NEIGHBOR_COUNT = 1'b1;

    typedef struct packed {
        logic                          cmd;
        logic [INDEX_BITS-1:0]         entry_index;
        logic signed [VALUE_BITS-1:0]  point_feature;
        logic [LABEL_BITS-1:0]         point_label;
        logic signed [VALUE_BITS-1:0]  query_value;
    } t_in_item;

    typedef struct packed {
        logic [LABEL_OUT_BITS-1:0] class_label;
        logic                      status;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_VOTE,
        ST_ARG
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic start_query;
        logic scan_rd;
        logic vote_step;
        logic arg_step;
        logic emit;
        logic emit_empty;
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic k_zero;
        logic scan_last;
        logic pipe_idle;
        logic vote_last;
        logic arg_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/core/knn_ctrl.sv =====
`default_nettype none

module knn_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_cmd,
    input  wire knn_pkg::t_dp_stat i_stat,
    output knn_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);
    import knn_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   start_acc;

    assign start_acc = i_start && (r_state == ST_IDLE);
    assign o_busy    = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_acc && (i_cmd == CMD_CLASSIFY) && !i_stat.n_zero) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_stat.pipe_idle) begin
                    n_state = i_stat.k_zero ? ST_ARG : ST_VOTE;
                end
            end
            ST_VOTE: begin
                if (i_stat.vote_last) begin
                    n_state = ST_ARG;
                end
            end
            ST_ARG: begin
                if (i_stat.arg_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load_wr     = start_acc && (i_cmd == CMD_LOAD);
                o_cmd.start_query = start_acc && (i_cmd == CMD_CLASSIFY) && !i_stat.n_zero;
                o_cmd.emit_empty  = start_acc && (i_cmd == CMD_CLASSIFY) && i_stat.n_zero;
            end
            ST_SCAN:  o_cmd.scan_rd = 1'b1;
            ST_DRAIN: o_cmd = '0;
            ST_VOTE:  o_cmd.vote_step = 1'b1;
            ST_ARG: begin
                o_cmd.arg_step = 1'b1;
                o_cmd.emit     = i_stat.arg_last;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/knn_dp.sv =====
`default_nettype none

module knn_dp #(
    parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
    parameter int MAX_K      = knn_pkg::MAX_K_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire knn_pkg::t_dp_cmd              i_cmd,
    input  wire knn_pkg::t_in_item             i_item,
    input  wire logic [knn_pkg::TSIZE_BITS-1:0] i_table_size,
    input  wire logic [knn_pkg::KCFG_BITS-1:0]  i_neighbor_count,
    output knn_pkg::t_dp_stat                  o_stat,
    output logic                               o_done,
    output knn_pkg::t_out_item                 o_result
);
    import knn_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(MAX_K + 1);

    // point table
    logic signed [VALUE_BITS-1:0] feat_mem [MAX_POINTS];
    logic [LABEL_BITS-1:0]        lab_mem  [MAX_POINTS];

    logic [NW-1:0]                r_n;
    logic [KW-1:0]                r_k;
    logic signed [VALUE_BITS-1:0] r_q;
    logic [NW-1:0]                r_scan_idx;

    logic                         r_v1;
    logic signed [VALUE_BITS-1:0] r_rd_feat;
    logic [LABEL_BITS-1:0]        r_rd_lab;
    logic                         r_v2;
    logic [DIST_BITS-1:0]         r_dist;
    logic [LABEL_BITS-1:0]        r_dlab;

    // sorted neighbor list
    logic                         r_cv [MAX_K];
    logic [DIST_BITS-1:0]         r_cd [MAX_K];
    logic [LABEL_BITS-1:0]        r_cl [MAX_K];

    logic [KW-1:0]                r_votes [NUM_LABELS];
    logic [KW-1:0]                r_vcnt;
    logic [LABEL_OUT_BITS-1:0]    r_aj;
    logic [KW-1:0]                r_best_votes;
    logic [LABEL_OUT_BITS-1:0]    r_best_lab;

    logic                         r_out_valid;
    t_out_item                    r_out;

    logic [NW-1:0]                n_eff;
    logic [KW-1:0]                k_eff;
    logic signed [DIST_BITS-1:0]  diff;
    logic [DIST_BITS-1:0]         abs_diff;
    logic [MAX_K-1:0]             gt;
    logic [MAX_K-1:0]             shift_in;
    logic [MAX_K-1:0]             prev_v;
    logic [MAX_K-1:0]             new_in;
    logic [DIST_BITS-1:0]         up_d [MAX_K];
    logic [LABEL_BITS-1:0]        up_l [MAX_K];
    logic [LABEL_BITS-1:0]        down_l [MAX_K];
    logic [LABEL_BITS-1:0]        vote_lab;
    logic                         arg_take;

    always_comb begin
        if (int'(i_table_size) > MAX_POINTS) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(i_table_size);
        end
        if (int'(i_neighbor_count) > MAX_K) begin
            k_eff = KW'(MAX_K);
        end else begin
            k_eff = KW'(i_neighbor_count);
        end
        if (int'(k_eff) > int'(n_eff)) begin
            k_eff = KW'(n_eff);
        end
    end

    assign o_stat.n_zero    = (n_eff == '0);
    assign o_stat.k_zero    = (r_k == '0);
    assign o_stat.scan_last = (r_scan_idx == r_n - NW'(1));
    assign o_stat.pipe_idle = !r_v1 && !r_v2;
    assign o_stat.vote_last = (r_vcnt == r_k - KW'(1));
    assign o_stat.arg_last  = (r_aj == LABEL_OUT_BITS'(NUM_LABELS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && (int'(i_item.entry_index) < MAX_POINTS)) begin
            feat_mem[AW'(i_item.entry_index)] <= i_item.point_feature;
            lab_mem[AW'(i_item.entry_index)]  <= i_item.point_label;
        end
        if (i_cmd.scan_rd) begin
            r_rd_feat <= feat_mem[r_scan_idx[AW-1:0]];
            r_rd_lab  <= lab_mem[r_scan_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_n <= n_eff;
            r_k <= k_eff;
            r_q <= i_item.query_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (i_cmd.start_query) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_rd) begin
                r_scan_idx <= r_scan_idx + NW'(1);
            end
            r_v1 <= i_cmd.scan_rd;
            r_v2 <= r_v1;
        end
    end

    assign diff     = DIST_BITS'(r_q) - DIST_BITS'(r_rd_feat);
    assign abs_diff = diff[DIST_BITS-1] ? DIST_BITS'(-diff) : DIST_BITS'(diff);

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_dist <= abs_diff;
            r_dlab <= r_rd_lab;
        end
    end

    // strict compare keeps equal distances in index order
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            gt[i] = r_cv[i] && (r_cd[i] > r_dist);
        end
    end

    for (genvar gi = 0; gi < MAX_K; gi++) begin : g_link
        if (gi == 0) begin : g_head
            assign shift_in[gi] = 1'b0;
            assign prev_v[gi]   = 1'b1;
            assign up_d[gi]     = r_dist;
            assign up_l[gi]     = r_dlab;
        end else begin : g_body
            assign shift_in[gi] = gt[gi-1];
            assign prev_v[gi]   = r_cv[gi-1];
            assign up_d[gi]     = r_cd[gi-1];
            assign up_l[gi]     = r_cl[gi-1];
        end
        if (gi == MAX_K - 1) begin : g_tail
            assign down_l[gi] = r_cl[gi];
        end else begin : g_mid
            assign down_l[gi] = r_cl[gi+1];
        end
        assign new_in[gi] = !shift_in[gi] && (gt[gi] || (!r_cv[gi] && prev_v[gi]));
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_K; i++) begin
            if (!i_rst_n || i_cmd.start_query) begin
                r_cv[i] <= 1'b0;
            end else if (r_v2 && (shift_in[i] || new_in[i])) begin
                r_cv[i] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_K; i++) begin
            if (r_v2) begin
                if (shift_in[i]) begin
                    r_cd[i] <= up_d[i];
                    r_cl[i] <= up_l[i];
                end else if (new_in[i]) begin
                    r_cd[i] <= r_dist;
                    r_cl[i] <= r_dlab;
                end
            end else if (i_cmd.vote_step) begin
                r_cl[i] <= down_l[i];
            end
        end
    end

    // votes: list shifts out through its head, one neighbor per cycle
    assign vote_lab = r_cl[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start_query) begin
            for (int j = 0; j < NUM_LABELS; j++) begin
                r_votes[j] <= '0;
            end
            r_vcnt <= '0;
        end else if (i_cmd.vote_step) begin
            if (int'(vote_lab) < NUM_LABELS) begin
                r_votes[vote_lab[LABEL_OUT_BITS-1:0]] <=
                    r_votes[vote_lab[LABEL_OUT_BITS-1:0]] + KW'(1);
            end
            r_vcnt <= r_vcnt + KW'(1);
        end
    end

    assign arg_take = (r_aj == '0) || (r_votes[r_aj] > r_best_votes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start_query) begin
            r_aj <= '0;
        end else if (i_cmd.arg_step) begin
            r_aj <= r_aj + LABEL_OUT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arg_step && arg_take) begin
            r_best_votes <= r_votes[r_aj];
            r_best_lab   <= r_aj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit || i_cmd.emit_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_empty) begin
            r_out.class_label <= '0;
            r_out.status      <= STATUS_EMPTY;
        end else if (i_cmd.emit) begin
            r_out.class_label <= arg_take ? r_aj : r_best_lab;
            r_out.status      <= STATUS_OK;
        end
    end

    assign o_done   = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/knn_classifier_1d_top.sv =====
// Channel   Handshake                        Payload
// command   start in, busy out               i_item (t_in_item)
// result    o_done strobe, one cycle         o_result (t_out_item)
// config    APB psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// A load command writes its table entry and leaves busy low.
// A classify command holds busy while it reads the n table entries, one table read
// per cycle, drains the read, distance and insertion registers, takes one vote per
// cycle from the k voters, then one label count per cycle for 16 labels.
// o_done pulses in the same cycle that busy falls; with an empty table, in the cycle
// after the accept. The receiver takes every result; reset is synchronous, active low.
`default_nettype none

module knn_classifier_1d_top #(
    parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
    parameter int MAX_K      = knn_pkg::MAX_K_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire knn_pkg::t_in_item                 i_item,
    output logic                                   o_done,
    output knn_pkg::t_out_item                     o_result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [knn_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [knn_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [knn_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready
);
    import knn_pkg::*;

    logic [TSIZE_BITS-1:0] r_table_size;
    logic [KCFG_BITS-1:0]  r_neighbor_count;
    logic                  reg_sel;
    logic                  wr_en;
    t_dp_cmd               dp_cmd;
    t_dp_stat              dp_stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size     <= '0;
            r_neighbor_count <= KCFG_BITS'(KCFG_RESET);
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_TABLE_SIZE:     r_table_size     <= pwdata[TSIZE_BITS-1:0];
                REG_NEIGHBOR_COUNT: r_neighbor_count <= pwdata[KCFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TABLE_SIZE:     prdata = APB_DATA_BITS'(r_table_size);
            REG_NEIGHBOR_COUNT: prdata = APB_DATA_BITS'(r_neighbor_count);
            default:            prdata = '0;
        endcase
    end

    knn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.cmd),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    knn_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_K      (MAX_K)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_item           (i_item),
        .i_table_size     (r_table_size),
        .i_neighbor_count (r_neighbor_count),
        .o_stat           (dp_stat),
        .o_done           (o_done),
        .o_result         (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/knn_checker.sv =====
`default_nettype none

module knn_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire knn_pkg::t_in_item  i_item,
    input wire logic               o_done,
    input wire knn_pkg::t_out_item o_result
);
    import knn_pkg::*;

    // result only once the engine has gone idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.cmd == CMD_LOAD)) |=> !o_done)
        else $error("load transaction produced a result");

    a_classify_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.cmd == CMD_CLASSIFY)) |=> (busy || o_done))
        else $error("classify transaction neither started nor answered");

    a_empty_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == STATUS_EMPTY)) |-> (o_result.class_label == '0))
        else $error("empty-table result with nonzero label");

endmodule

bind knn_classifier_1d_top knn_checker u_knn_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
